// ===== sv/mhdcfl_pkg.sv =====
// Shared types and constants for the MHD CFL time step unit.
// No dependencies.
package mhdcfl_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  localparam logic [1:0] REG_GAMMA   = 2'd0;
  localparam logic [1:0] REG_COURANT = 2'd1;
  localparam logic [1:0] REG_MINCELL = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  function automatic logic [30:0] sat31(input logic [63:0] v);
    return (v > {33'b0, SAT31}) ? SAT31 : v[30:0];
  endfunction

endpackage

// ===== sv/mhdcfl_cell_if.sv =====
// Request channel carrying one cell's primitive state.
// Depends on nothing.
interface mhdcfl_cell_if;
  logic        valid;
  logic        ready;
  logic [30:0] density;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [30:0] pressure;
  logic [31:0] field_x;
  logic [31:0] field_y;
  logic [31:0] field_z;
  logic        last_cell;

  modport source (output valid, density, vel_x, vel_y, pressure, field_x, field_y,
                  field_z, last_cell, input ready);
  modport sink (input valid, density, vel_x, vel_y, pressure, field_x, field_y,
                field_z, last_cell, output ready);
endinterface

// ===== sv/mhdcfl_result_if.sv =====
// Result channel carrying the per-sweep speed and time step.
// Depends on nothing.
interface mhdcfl_result_if;
  logic        valid;
  logic        ready;
  logic [30:0] max_speed;
  logic [30:0] time_step;
  logic        no_signal;

  modport source (output valid, max_speed, time_step, no_signal, input ready);
  modport sink (input valid, max_speed, time_step, no_signal, output ready);
endinterface

// ===== sv/mhdcfl_arith.sv =====
// Shared serial arithmetic unit: shift-add multiply, restoring divide,
// two-bit-per-cycle integer square root. Depends on mhdcfl_pkg.
module mhdcfl_arith
  import mhdcfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  arith_req_t  req,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] result
);

  arith_op_t   op_r;
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] xs;
  logic [31:0] ys;
  logic [63:0] acc;

  logic [33:0] div_rem;
  logic [35:0] sq_rem;
  logic [35:0] sq_trial;
  logic        last_step;

  assign div_rem  = {acc[32:0], xs[63]};
  assign sq_rem   = {acc[33:0], xs[63:62]};
  assign sq_trial = {2'b00, ys, 2'b01};
  assign last_step = (op_r == OP_DIV) ? (cnt == 6'd63) : (cnt == 6'd31);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else if (!busy) begin
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_r <= req.op;
        acc  <= '0;
        unique case (req.op)
          OP_MUL: begin
            xs <= {32'b0, a[31:0]};
            ys <= b;
          end
          OP_DIV: begin
            xs <= a;
            ys <= b;
          end
          default: begin
            xs <= a;
            ys <= '0;
          end
        endcase
      end
    end else begin
      cnt <= cnt + 6'd1;
      unique case (op_r)
        OP_MUL: begin
          if (ys[0]) acc <= acc + xs;
          xs <= {xs[62:0], 1'b0};
          ys <= {1'b0, ys[31:1]};
        end
        OP_DIV: begin
          if (div_rem >= {2'b00, ys}) begin
            acc <= {30'b0, div_rem - {2'b00, ys}};
            xs  <= {xs[62:0], 1'b1};
          end else begin
            acc <= {30'b0, div_rem};
            xs  <= {xs[62:0], 1'b0};
          end
        end
        default: begin
          xs <= {xs[61:0], 2'b00};
          if (sq_rem >= sq_trial) begin
            acc <= {28'b0, sq_rem - sq_trial};
            ys  <= {ys[30:0], 1'b1};
          end else begin
            acc <= {28'b0, sq_rem};
            ys  <= {ys[30:0], 1'b0};
          end
        end
      endcase
      if (last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  result = acc;
      OP_DIV:  result = xs;
      default: result = {32'b0, ys};
    endcase
  end

endmodule

// ===== sv/mhd_cfl_time_step_unit.sv =====
// MHD fast magnetosonic CFL time step unit, top level.
// Depends on mhdcfl_pkg, mhdcfl_cell_if, mhdcfl_result_if, mhdcfl_arith.
// Each cell takes 7 multiplies, 4 roots and 4 divides in series on the shared serial
// unit, plus the request state and two passes through the update state.
// The last cell of a sweep adds a multiply and a divide for dt unless Ch is zero; the
// next cell may enter while its result waits. Sync reset restores register defaults, clears maxima.
module mhd_cfl_time_step_unit
  import mhdcfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  mhdcfl_cell_if.sink        cell_req,
  mhdcfl_result_if.source    result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MBX, S_MBY, S_MBZ, S_DCA, S_MGP, S_DCS, S_MSS,
    S_DBD, S_MT, S_SQ1, S_SQ2, S_UPD, S_MCM, S_DDT, S_FIN
  } state_t;

  state_t      state;
  logic        issued;
  logic [17:0] gamma_ratio;
  logic [16:0] courant_number;
  logic [30:0] min_cell_size;

  logic [30:0] rho, p, ca2, cs2, s, maxx, maxy, cf;
  logic [31:0] vx, vy, bx, by, bz, inner;
  logic [63:0] bx2, by2, tmp, s2, t;
  logic        last, dir, zero_ch;

  arith_req_t  areq;
  logic [63:0] aa;
  logic [31:0] ab;
  logic        adone;
  logic [63:0] ares;

  logic [30:0] ch;
  logic [63:0] half;
  logic [30:0] sd;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign pready = 1'b1;
  assign ch = (maxx > maxy) ? maxx : maxy;
  assign half = {33'b0, sat31(({33'b0, s} + {32'b0, inner}) >> 1)} << FRAC_BITS;
  assign sd = sat31({33'b0, cf} + {32'b0, dir ? vy : vx});
  assign cell_req.ready = (state == S_IDLE);

  always_comb begin
    case (paddr[3:2])
      REG_GAMMA:   prdata = {14'b0, gamma_ratio};
      REG_COURANT: prdata = {15'b0, courant_number};
      REG_MINCELL: prdata = {1'b0, min_cell_size};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    areq.start = !issued;
    areq.op    = OP_MUL;
    aa = '0;
    ab = '0;
    case (state)
      S_MBX: begin aa = {32'b0, bx}; ab = bx; end
      S_MBY: begin aa = {32'b0, by}; ab = by; end
      S_MBZ: begin aa = {32'b0, bz}; ab = bz; end
      S_DCA: begin areq.op = OP_DIV; aa = tmp; ab = {1'b0, rho}; end
      S_MGP: begin aa = {46'b0, gamma_ratio}; ab = {1'b0, p}; end
      S_DCS: begin areq.op = OP_DIV; aa = tmp; ab = {1'b0, rho}; end
      S_MSS: begin aa = {33'b0, s}; ab = {1'b0, s}; end
      S_DBD: begin areq.op = OP_DIV; aa = dir ? by2 : bx2; ab = {1'b0, rho}; end
      S_MT:  begin aa = {33'b0, cs2}; ab = {1'b0, tmp[30:0]}; end
      S_SQ1: begin areq.op = OP_SQRT; aa = (s2 > t) ? s2 - t : '0; end
      S_SQ2: begin areq.op = OP_SQRT; aa = half; end
      S_MCM: begin aa = {47'b0, courant_number}; ab = {1'b0, min_cell_size}; end
      S_DDT: begin areq.op = OP_DIV; aa = tmp; ab = {1'b0, ch}; end
      default: areq.start = 1'b0;
    endcase
  end

  mhdcfl_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (areq),
    .a      (aa),
    .b      (ab),
    .done   (adone),
    .result (ares)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      issued         <= 1'b0;
      gamma_ratio    <= 18'd91750;
      courant_number <= 17'd52429;
      min_cell_size  <= 31'd655;
      maxx           <= '0;
      maxy           <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_GAMMA:   gamma_ratio    <= pwdata[17:0];
          REG_COURANT: courant_number <= pwdata[16:0];
          REG_MINCELL: min_cell_size  <= pwdata[30:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) result.valid <= 1'b0;
      if (areq.start) issued <= 1'b1;
      if (adone) issued <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cell_req.valid) begin
            rho   <= (cell_req.density == '0) ? 31'd1 : cell_req.density;
            p     <= cell_req.pressure;
            vx    <= mag32(cell_req.vel_x);
            vy    <= mag32(cell_req.vel_y);
            bx    <= mag32(cell_req.field_x);
            by    <= mag32(cell_req.field_y);
            bz    <= mag32(cell_req.field_z);
            last  <= cell_req.last_cell;
            dir   <= 1'b0;
            state <= S_MBX;
          end
        end
        S_MBX: if (adone) begin bx2 <= ares; state <= S_MBY; end
        S_MBY: if (adone) begin by2 <= ares; state <= S_MBZ; end
        S_MBZ: if (adone) begin tmp <= bx2 + by2 + ares; state <= S_DCA; end
        S_DCA: if (adone) begin ca2 <= sat31(ares); state <= S_MGP; end
        S_MGP: if (adone) begin tmp <= ares; state <= S_DCS; end
        S_DCS: if (adone) begin
          cs2   <= sat31(ares);
          s     <= sat31({33'b0, sat31(ares)} + {33'b0, ca2});
          state <= S_MSS;
        end
        S_MSS: if (adone) begin s2 <= ares; state <= S_DBD; end
        S_DBD: if (adone) begin tmp <= {33'b0, sat31(ares)}; state <= S_MT; end
        S_MT:  if (adone) begin t <= {ares[61:0], 2'b00}; state <= S_SQ1; end
        S_SQ1: if (adone) begin inner <= ares[31:0]; state <= S_SQ2; end
        S_SQ2: if (adone) begin cf <= ares[30:0]; state <= S_UPD; end
        S_UPD: begin
          if (dir) begin
            if (sd > maxy) maxy <= sd;
          end else begin
            if (sd > maxx) maxx <= sd;
          end
          if (!dir) begin
            dir   <= 1'b1;
            state <= S_DBD;
          end else if (!last) begin
            state <= S_IDLE;
          end else if (((sd > maxy) ? sd : maxy) == '0 && maxx == '0) begin
            zero_ch <= 1'b1;
            state   <= S_FIN;
          end else begin
            zero_ch <= 1'b0;
            state   <= S_MCM;
          end
        end
        S_MCM: if (adone) begin tmp <= ares; state <= S_DDT; end
        S_DDT: if (adone) begin tmp <= {33'b0, sat31(ares)}; state <= S_FIN; end
        S_FIN: begin
          if (!result.valid) begin
            result.valid     <= 1'b1;
            result.max_speed <= ch;
            result.time_step <= zero_ch ? SAT31 : tmp[30:0];
            result.no_signal <= zero_ch;
            maxx  <= '0;
            maxy  <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cell_req.valid && cell_req.ready |=> !cell_req.ready)
    else $error("cell request accepted twice in a row");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.no_signal |-> result.max_speed == '0)
    else $error("no_signal with nonzero speed");
  a_done_when_issued: assert property (@(posedge clk) disable iff (rst)
    adone |-> issued)
    else $error("arith done without request");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mhd_cfl_time_step_unit: directed and random cell sweeps
// against a built-in fixed-point fast-speed and time-step predictor. Depends on
// mhdcfl_pkg, the cell and result interfaces and mhd_cfl_time_step_unit.
module tb;
  import mhdcfl_pkg::*;

  localparam int SETTLE = 1000;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [30:0] density;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [30:0] pressure;
    logic [31:0] field_x;
    logic [31:0] field_y;
    logic [31:0] field_z;
    logic        last_cell;
  } cell_t;

  typedef struct {
    logic [30:0] max_speed;
    logic [30:0] time_step;
    logic        no_signal;
  } sweep_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mhdcfl_cell_if cell_ch ();
  mhdcfl_result_if res_ch ();

  mhd_cfl_time_step_unit u_top (
    .clk(clk), .rst(rst), .cell_req(cell_ch), .result(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cell_t  cell_q[$];
  sweep_t sweep_q[$];
  logic [63:0] gamma_r, courant_r, mincell_r;
  logic [31:0] peak_x, peak_y;
  int mismatches;
  int idle_cycles;
  int gap_left, burst_left;
  int stall_mode;
  int queued_n, accepted_n;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] clip31(input logic [63:0] v);
    return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
  endfunction

  function automatic logic [63:0] magnitude(input logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    if (v[31]) w = ({32'b0, ~v} + 64'd1);
    return w;
  endfunction

  function automatic logic [63:0] fast_wave(input logic [63:0] s, cs2, bd2, rho);
    logic [63:0] s2, bdr, t, rad, half;
    s2 = s * s;
    bdr = clip31(bd2 / rho);
    t = 64'd4 * (cs2 * bdr);
    rad = (s2 > t) ? s2 - t : 64'd0;
    half = clip31((s + floor_root(rad)) >> 1);
    return floor_root(half << FRAC_BITS);
  endfunction

  function automatic bit sweep_step(input cell_t c, output sweep_t r);
    logic [63:0] rho, bx, by, bz, bx2, by2, bsq, ca2, cs2, s, sx, sy, ch, dt;
    rho = {33'b0, c.density};
    if (rho == 0) rho = 64'd1;
    bx = magnitude(c.field_x);
    by = magnitude(c.field_y);
    bz = magnitude(c.field_z);
    bx2 = bx * bx;
    by2 = by * by;
    bsq = bx2 + by2 + bz * bz;
    ca2 = clip31(bsq / rho);
    cs2 = clip31((gamma_r * {33'b0, c.pressure}) / rho);
    s = clip31(cs2 + ca2);
    sx = clip31(fast_wave(s, cs2, bx2, rho) + magnitude(c.vel_x));
    sy = clip31(fast_wave(s, cs2, by2, rho) + magnitude(c.vel_y));
    if (sx > peak_x) peak_x = sx[31:0];
    if (sy > peak_y) peak_y = sy[31:0];
    r = '{default: '0};
    if (!c.last_cell) return 1'b0;
    ch = clip31({32'b0, (peak_x > peak_y) ? peak_x : peak_y});
    r.max_speed = ch[30:0];
    if (ch == 0) begin
      r.time_step = SAT31;
      r.no_signal = 1'b1;
    end else begin
      dt = clip31((courant_r * mincell_r) / ch);
      r.time_step = dt[30:0];
      r.no_signal = 1'b0;
    end
    peak_x = '0;
    peak_y = '0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] spread(input bit signed_f);
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if (signed_f && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic cell_t random_cell(input int last_odds);
    cell_t c;
    logic [31:0] d;
    logic [31:0] pr;
    d = spread(1'b0);
    if ($urandom_range(0, 40) != 0 && d[30:0] == 0) d = 32'd1;
    c.density = d[30:0];
    c.vel_x = spread(1'b1);
    c.vel_y = spread(1'b1);
    pr = spread(1'b0);
    c.pressure = pr[30:0];
    c.field_x = spread(1'b1);
    c.field_y = spread(1'b1);
    c.field_z = spread(1'b1);
    if ($urandom_range(0, 30) == 0) c.field_x = 32'h8000_0000;
    c.last_cell = ($urandom_range(1, last_odds) == 1);
    return c;
  endfunction

  function automatic cell_t make_cell(input logic [30:0] rho, p,
                                      input logic [31:0] vx, vy, bx, by, bz,
                                      input logic last);
    cell_t c;
    c.density = rho; c.pressure = p;
    c.vel_x = vx; c.vel_y = vy;
    c.field_x = bx; c.field_y = by; c.field_z = bz;
    c.last_cell = last;
    return c;
  endfunction

  task automatic add_cell(input cell_t c);
    cell_q.insert(cell_q.size(), c);
    queued_n++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_GAMMA:   gamma_r = {32'b0, val & 32'h3FFFF};
      REG_COURANT: courant_r = {32'b0, val & 32'h1FFFF};
      REG_MINCELL: mincell_r = {32'b0, val & 32'h7FFF_FFFF};
      default: ;
    endcase
  endtask

  task automatic drain();
    while (accepted_n != queued_n || sweep_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_phase(input logic [31:0] g, c, m, input int n, input int odds);
    reg_write(REG_GAMMA, g);
    reg_write(REG_COURANT, c);
    reg_write(REG_MINCELL, m);
    stall_mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) add_cell(random_cell(odds));
    drain();
  endtask

  // driver: bursts with gaps
  always @(posedge clk) begin
    if (rst) begin
      cell_ch.valid <= 0;
      gap_left <= 0;
      burst_left <= 1;
    end else if (!cell_ch.valid || cell_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cell_ch.valid <= 0;
      end else if (cell_q.size() != 0) begin
        cell_t c;
        c = cell_q.pop_front();
        cell_ch.valid <= 1;
        cell_ch.density <= c.density;
        cell_ch.vel_x <= c.vel_x;
        cell_ch.vel_y <= c.vel_y;
        cell_ch.pressure <= c.pressure;
        cell_ch.field_x <= c.field_x;
        cell_ch.field_y <= c.field_y;
        cell_ch.field_z <= c.field_z;
        cell_ch.last_cell <= c.last_cell;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 700);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cell_ch.valid <= 0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) res_ch.ready <= 0;
    else case (stall_mode)
      0: res_ch.ready <= 1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // predictor on accepted cells
  always @(posedge clk) begin
    if (!rst && cell_ch.valid && cell_ch.ready) begin
      cell_t c;
      sweep_t r;
      c = make_cell(cell_ch.density, cell_ch.pressure, cell_ch.vel_x, cell_ch.vel_y,
                    cell_ch.field_x, cell_ch.field_y, cell_ch.field_z, cell_ch.last_cell);
      if (sweep_step(c, r)) sweep_q.insert(sweep_q.size(), r);
      accepted_n++;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sweep_t e;
      if (sweep_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: Ch=%0d dt=%0d flag=%0b",
                                       res_ch.max_speed, res_ch.time_step, res_ch.no_signal);
      end else begin
        e = sweep_q.pop_front();
        if (e.max_speed !== res_ch.max_speed || e.time_step !== res_ch.time_step ||
            e.no_signal !== res_ch.no_signal) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp Ch=%0d dt=%0d flag=%0b, got Ch=%0d dt=%0d flag=%0b",
                     e.max_speed, e.time_step, e.no_signal,
                     res_ch.max_speed, res_ch.time_step, res_ch.no_signal);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || psel || (cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("mhd_cfl_time_step_unit: mismatch");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cell_ch.valid = 0;
    cell_ch.density = 0; cell_ch.vel_x = 0; cell_ch.vel_y = 0; cell_ch.pressure = 0;
    cell_ch.field_x = 0; cell_ch.field_y = 0; cell_ch.field_z = 0; cell_ch.last_cell = 0;
    res_ch.ready = 0;
    gamma_r = 64'd91750; courant_r = 64'd52429; mincell_r = 64'd655;
    peak_x = '0; peak_y = '0;
    mismatches = 0; idle_cycles = 0; stall_mode = 0;
    queued_n = 0; accepted_n = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // directed at reset defaults
    add_cell(make_cell(31'd0, 31'd0, 0, 0, 0, 0, 0, 1'b1));
    add_cell(make_cell(31'd1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    add_cell(make_cell(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 0, 0, 1'b0));
    add_cell(make_cell(31'h10000, 31'h10000, 32'hFFFF_0000, 32'h8000,
                       32'h10000, 32'hFFFF_0000, 32'h20000, 1'b1));
    add_cell(make_cell(31'h10000, 31'd0, 0, 0, 32'h10000, 0, 0, 1'b0));
    add_cell(make_cell(31'h10000, 31'd0, 0, 0, 0, 32'h10000, 0, 1'b1));
    add_cell(make_cell(31'h40000, 31'h8000, 32'd1, 32'hFFFF_FFFF, 0, 0, 32'h1, 1'b1));
    add_cell(make_cell(31'd0, 31'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
    add_cell(make_cell(31'h2AAA_AAAA, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
    add_cell(make_cell(31'h10000, 31'h10000, 0, 0, 32'h30000, 32'h30000, 0, 1'b0));
    add_cell(make_cell(31'h10000, 31'h10000, 0, 0, 0, 0, 0, 1'b1));
    drain();

    // extremes: slowest gas, courant 1.0 and largest cell size, dt saturates
    reg_write(REG_GAMMA, 32'd196608);
    reg_write(REG_COURANT, 32'd65536);
    reg_write(REG_MINCELL, 32'h7FFF_FFFF);
    add_cell(make_cell(31'h7FFF_FFFF, 31'd1, 32'd1, 0, 0, 0, 0, 1'b1));
    add_cell(make_cell(31'h10000, 31'd0, 0, 0, 0, 0, 0, 1'b1));
    add_cell(make_cell(31'd5, 31'd7, 32'hFFFF_FFF0, 32'd3, 32'd9, 32'd2, 0, 1'b1));
    drain();

    load_phase(32'd196608, 32'd65536, 32'h7FFF_FFFF, 180, 10);
    load_phase(32'd65536, 32'd0, 32'd1, 150, 10);
    load_phase(32'd91750, 32'd52429, 32'd655, 150, 8);
    load_phase($urandom_range(65536, 196608), $urandom_range(0, 65536),
               $urandom_range(1, 32'h7FFF_FFFF), 150, 12);
    load_phase(32'd65536, 32'd65536, 32'd1, 120, 10);

    if (mismatches == 0 && sweep_q.size() == 0) begin
      $display("mhd_cfl_time_step_unit: match");
    end else begin
      $display("mhd_cfl_time_step_unit: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/mhdcfl_pkg.sv
sv/mhdcfl_cell_if.sv
sv/mhdcfl_result_if.sv
sv/mhdcfl_arith.sv
sv/mhd_cfl_time_step_unit.sv
test/tb.sv
